// File: sv/bridge_adc_serial_reader_avg_assert.svh
// Assertion macros shared by the bridge ADC reader modules.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef BRIDGE_ADC_SERIAL_READER_AVG_ASSERT_SVH
`define BRIDGE_ADC_SERIAL_READER_AVG_ASSERT_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define BSRA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// A condition that, when true, must be followed by another in the same cycle.
`define BSRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// A condition that, when true, must be followed by another in the next cycle.
`define BSRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define BSRA_ASSERT(label, clk, rst, prop)
`define BSRA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BSRA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/bsra_pkg.sv
// Types and constants for the bridge ADC serial reader with averaging.
// Used by bsra_average and bridge_adc_serial_reader_avg; depends on nothing.
package bsra_pkg;

   // Number of readings folded into one average (1 to 12).
   localparam int READINGS = 6;

   localparam int WORD_W  = 24;
   localparam int SCALE_W = 18;
   localparam int SUM_W   = 21;
   localparam int COUNT_W = 4;
   localparam int GAP_W   = 24;
   localparam int BIT_W   = 5;

   localparam logic [GAP_W-1:0]  GAP_RESET = 24'h8F_FFFF;
   localparam logic [WORD_W-1:0] SIGN_FLIP = 24'h80_0000;
   localparam logic [BIT_W-1:0]  WORD_BITS = 5'd24;

   // Largest value of one reading divided by 100.
   localparam int SCALE_MAX = 167772;

   // Reading / 100 is (reading >> 2) / 25, done as a multiply by
   // ceil(2^27 / 25); exact for every 22-bit operand.
   localparam int SCALE_SHIFT = 27;
   localparam logic [22:0] SCALE_MUL = 23'(((1 << SCALE_SHIFT) + 24) / 25);

   // Sum / READINGS as a multiply by ceil(2^25 / READINGS); the rounding
   // error stays below one for any 21-bit sum and any count up to 12.
   localparam int AVG_SHIFT = 25;
   localparam int AVG_MUL_W = 26;
   localparam logic [AVG_MUL_W-1:0] AVG_MUL =
      AVG_MUL_W'(((1 << AVG_SHIFT) + READINGS - 1) / READINGS);
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(READINGS - 1);

   // Serial sequencer states.
   typedef enum logic [5:0] {
      PH_GAP   = 6'b000001,
      PH_WAIT  = 6'b000010,
      PH_HIGH  = 6'b000100,
      PH_LOW   = 6'b001000,
      PH_XHIGH = 6'b010000,
      PH_XLOW  = 6'b100000
   } phase_type;

   // Strobes from the sequencer to the averager, already qualified by an
   // accepted beat.
   typedef struct packed {
      logic load_scale;
      logic commit;
   } avg_ctl_type;

   // Per-beat results of the averager.
   typedef struct packed {
      logic                    reading_done;
      logic [WORD_W-1:0]       reading_value;
      logic                    average_done;
      logic [SCALE_W-1:0]      average_value;
   } avg_out_type;

endpackage

// File: sv/bsra_average.sv
// Scales each finished reading by 1/100, keeps the running sum and emits the
// average every READINGS readings. Depends on bsra_pkg and the assertion header.
`include "bridge_adc_serial_reader_avg_assert.svh"

module bsra_average (
   input  logic                         clock,
   input  logic                         reset,
   input  bsra_pkg::avg_ctl_type        ctl,
   input  logic [bsra_pkg::WORD_W-1:0]  word,
   output bsra_pkg::avg_out_type        result
);

   logic [bsra_pkg::WORD_W-1:0]  flipped;
   logic [44:0]                  scale_prod;
   logic [bsra_pkg::SCALE_W-1:0] scale_ff;
   logic [bsra_pkg::SCALE_W-1:0] scale_in;
   logic [bsra_pkg::SUM_W-1:0]   sum_ff;
   logic [bsra_pkg::SUM_W-1:0]   sum_in;
   logic [bsra_pkg::SUM_W-1:0]   sum_new;
   logic [bsra_pkg::COUNT_W-1:0] count_ff;
   logic [bsra_pkg::COUNT_W-1:0] count_in;
   logic [bsra_pkg::SUM_W+bsra_pkg::AVG_MUL_W-1:0] avg_prod;
   logic                         last_one;

   // Offset-binary reading and its scaled value, taken on the last clock-high tick.
   assign flipped    = word ^ bsra_pkg::SIGN_FLIP;
   assign scale_prod = 45'(flipped[bsra_pkg::WORD_W-1:2]) * 45'(bsra_pkg::SCALE_MUL);
   assign scale_in   = ctl.load_scale
                       ? scale_prod[bsra_pkg::SCALE_SHIFT+bsra_pkg::SCALE_W-1:
                                    bsra_pkg::SCALE_SHIFT]
                       : scale_ff;

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

   // Sum update and the divide by READINGS on the committing beat.
   assign sum_new  = sum_ff + bsra_pkg::SUM_W'(scale_ff);
   assign last_one = (count_ff >= bsra_pkg::LAST_COUNT);
   assign avg_prod = (bsra_pkg::SUM_W+bsra_pkg::AVG_MUL_W)'(sum_new)
                     * (bsra_pkg::SUM_W+bsra_pkg::AVG_MUL_W)'(bsra_pkg::AVG_MUL);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (ctl.commit) begin
         if (last_one) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_new;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // Results are zero on beats that finish nothing.
   always_comb begin
      result.reading_done  = ctl.commit;
      result.reading_value = ctl.commit ? flipped : '0;
      result.average_done  = ctl.commit && last_one;
      result.average_value = (ctl.commit && last_one)
                             ? avg_prod[bsra_pkg::AVG_SHIFT+bsra_pkg::SCALE_W-1:
                                        bsra_pkg::AVG_SHIFT]
                             : '0;
   end

   // The count wraps before it reaches READINGS.
   `BSRA_ASSERT(a_count_bound, clock, reset, count_ff < bsra_pkg::COUNT_W'(bsra_pkg::READINGS))
   // The sum never holds more than READINGS-1 scaled readings.
   `BSRA_ASSERT(a_sum_bound, clock, reset, sum_ff <= bsra_pkg::SUM_W'((bsra_pkg::READINGS - 1) * bsra_pkg::SCALE_MAX))
   // Emitting an average restarts the sum and the count.
   `BSRA_ASSERT_NEXT(a_restart, clock, reset, ctl.commit && last_one, sum_ff == '0 && count_ff == '0)

endmodule

// File: sv/bridge_adc_serial_reader_avg.sv
// Top level of the tick-level bridge ADC serial reader with averaging.
// Depends on bsra_pkg, bsra_average and the assertion header.
//
//  channel | dir | handshake            | content
//  --------+-----+----------------------+-------------------------------------------
//  req     | in  | req_tvalid/tready    | one tick: sampled data-out level
//  rsp     | out | rsp_tvalid/tready    | one tick: clock level, reading, average
//  csr     | in  | csr_valid/ready      | gap_ticks write, always ready
//
// Every accepted req beat yields exactly one rsp beat, in the following cycle; a new
// beat is taken every cycle while the output register is empty or being drained.
// The only multiplies (reading/100 and sum/READINGS) sit on different ticks of
// the serial sequence; reading/100 feeds the scale register, sum/READINGS the
// output register. Reset is synchronous and active high; gap_ticks returns to
// 0x8FFFFF. A stalled rsp holds its beat and blocks req until it is taken.
`include "bridge_adc_serial_reader_avg_assert.svh"

module bridge_adc_serial_reader_avg (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] dout_level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] sck_level, [24:1] reading_value,
                                    // [42:25] average_value, [47:43] zero
   output logic [1:0]  rsp_tuser,   // [0] reading_done, [1] average_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data     // gap_ticks
);

   logic                        accept;
   logic                        dout;
   logic [bsra_pkg::GAP_W-1:0]  gap_ticks_ff;
   bsra_pkg::phase_type         phase_ff;
   bsra_pkg::phase_type         phase_in;
   logic [bsra_pkg::GAP_W-1:0]  gap_count_ff;
   logic [bsra_pkg::GAP_W-1:0]  gap_count_in;
   logic [bsra_pkg::BIT_W-1:0]  bit_count_ff;
   logic [bsra_pkg::BIT_W-1:0]  bit_count_in;
   logic [bsra_pkg::WORD_W-1:0] shift_ff;
   logic [bsra_pkg::WORD_W-1:0] shift_in;
   logic                        sck;
   logic                        wait_now;
   bsra_pkg::avg_ctl_type       step_ctl;
   bsra_pkg::avg_ctl_type       avg_ctl;
   bsra_pkg::avg_out_type       avg_out;
   logic                        rsp_valid_ff;
   logic [47:0]                 rsp_data_ff;
   logic [1:0]                  rsp_user_ff;

   assign accept = req_tvalid && req_tready;
   assign dout   = req_tdata[0];

   // Configuration register, writable at any time.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= bsra_pkg::GAP_RESET;
      end else if (csr_valid) begin
         gap_ticks_ff <= csr_data;
      end
   end

   // Serial sequencer: next state for one tick.
   always_comb begin
      phase_in     = phase_ff;
      gap_count_in = gap_count_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      sck          = 1'b0;
      wait_now     = 1'b0;
      step_ctl     = '0;
      case (phase_ff)
         bsra_pkg::PH_WAIT: begin
            wait_now = 1'b1;
         end
         bsra_pkg::PH_HIGH: begin
            sck      = 1'b1;
            phase_in = bsra_pkg::PH_LOW;
         end
         bsra_pkg::PH_LOW: begin
            shift_in     = {shift_ff[bsra_pkg::WORD_W-2:0], dout};
            bit_count_in = bit_count_ff + 1'b1;
            phase_in     = (bit_count_in >= bsra_pkg::WORD_BITS)
                           ? bsra_pkg::PH_XHIGH : bsra_pkg::PH_HIGH;
         end
         bsra_pkg::PH_XHIGH: begin
            sck                 = 1'b1;
            step_ctl.load_scale = 1'b1;
            phase_in            = bsra_pkg::PH_XLOW;
         end
         bsra_pkg::PH_XLOW: begin
            step_ctl.commit = 1'b1;
            gap_count_in    = '0;
            phase_in        = bsra_pkg::PH_GAP;
         end
         default: begin
            // Gap wait, also taken for any code outside the state set.
            if (gap_count_ff < gap_ticks_ff) begin
               gap_count_in = gap_count_ff + 1'b1;
               phase_in     = bsra_pkg::PH_GAP;
            end else begin
               gap_count_in = '0;
               wait_now     = 1'b1;
            end
         end
      endcase

      // Waiting for data-out low; the gap end falls through to here as well.
      if (wait_now) begin
         if (!dout) begin
            bit_count_in = '0;
            shift_in     = '0;
            phase_in     = bsra_pkg::PH_HIGH;
         end else begin
            phase_in     = bsra_pkg::PH_WAIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bsra_pkg::PH_GAP;
         gap_count_ff <= '0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         gap_count_ff <= gap_count_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
      end
   end

   // Scaling, summing and averaging.
   assign avg_ctl.load_scale = step_ctl.load_scale && accept;
   assign avg_ctl.commit     = step_ctl.commit && accept;

   bsra_average u_average (
      .clock  (clock),
      .reset  (reset),
      .ctl    (avg_ctl),
      .word   (shift_ff),
      .result (avg_out)
   );

   // Output register; it drains and refills in the same cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {5'd0, avg_out.average_value, avg_out.reading_value, sck};
         rsp_user_ff <= {avg_out.average_done, avg_out.reading_done};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A finished reading is reported on a clock-low tick.
   `BSRA_ASSERT_IMPL(a_done_sck_low, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tdata[0])
   // An average only comes with a finished reading.
   `BSRA_ASSERT_IMPL(a_avg_with_reading, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0])
   // Every accepted clock-high tick of a data bit is followed by its low tick.
   `BSRA_ASSERT_NEXT(a_high_then_low, clock, reset, accept && phase_ff == bsra_pkg::PH_HIGH, phase_ff == bsra_pkg::PH_LOW)
   // The bit counter never passes the word length.
   `BSRA_ASSERT(a_bit_bound, clock, reset, bit_count_ff <= bsra_pkg::WORD_BITS)

endmodule
